>>> sv/sct_pkg.sv
// Types and codes shared by the sleep countdown table.
package sct_pkg;

  localparam logic FuncSet  = 1'b0;
  localparam logic FuncTick = 1'b1;

  localparam int unsigned SlotW  = 5;
  localparam int unsigned TicksW = 16;

  typedef struct packed {
    logic              func;
    logic [SlotW-1:0]  slot;
    logic [TicksW-1:0] ticks;
  } in_beat_t;

  typedef struct packed {
    logic             is_wake;
    logic [SlotW-1:0] wake_slot;
    logic             last;
  } out_beat_t;

endpackage

>>> sv/sleep_countdown_table.sv
// Per-slot countdown timer table: slot counters in one synchronous RAM.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes set and tick beats.
// A set beat writes one slot's count (zero cancels) and gives no output.
// A tick beat starts a sweep over all NUM_SLOTS slots in ascending order,
// one slot per cycle unless an output stall holds it: the counter RAM is
// read in a registered stage ahead of the decrement and write-back.
// Each counter that falls to zero sends a wake beat naming its slot; every
// tick closes with one marker beat flagged last. in_stall_o stays high for
// the whole sweep and the marker, so items are handled one at a time.
// Output channel (out_valid_o / out_stall_i / out_data_o) is a register;
// a stall there holds the sweep at the slot that wants to send, and a new
// item may be taken while the marker still waits to be taken.
// Reset clears the per-slot valid bits, so all counters read as zero
// at once; no clearing pass is needed.
module sleep_countdown_table_core #(
  parameter int unsigned NUM_SLOTS   = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sct_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sct_pkg::out_beat_t out_data_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [6:0] NumSlots7 = 7'(NUM_SLOTS);
  localparam logic [CntW-1:0] NumSlotsC = CntW'(NUM_SLOTS);
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0] CountMax32 = 32'(CountMax);
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSweep = 3'b010,
    StMark  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0] mem_q [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [NUM_SLOTS-1:0]   vld_q, vld_d;

  logic                   p_valid_q, p_valid_d;
  logic [IdxW-1:0]        p_idx_q, p_idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   out_valid_q, out_valid_d;
  sct_pkg::out_beat_t     out_q, out_d;

  logic                   we, re;
  logic [IdxW-1:0]        waddr, raddr;
  logic [COUNT_WIDTH-1:0] wdata;

  logic                   in_acc, out_free;
  logic [COUNT_WIDTH-1:0] cur;
  logic                   p_wake, adv;
  logic [31:0]            ticks32;
  logic [COUNT_WIDTH-1:0] set_val;
  logic [5:0]             set_slot6, p_idx6;
  logic                   set_in_range;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cur    = vld_q[p_idx_q] ? rd_data_q : '0;
  assign p_wake = p_valid_q && (cur == CountOne);
  assign adv    = !p_wake || out_free;

  assign ticks32      = 32'(in_data_i.ticks);
  assign set_val      = (ticks32 > CountMax32) ? CountMax : ticks32[COUNT_WIDTH-1:0];
  assign set_slot6    = {1'b0, in_data_i.slot};
  assign set_in_range = {1'b0, set_slot6} < NumSlots7;
  assign p_idx6       = 6'(p_idx_q);

  always_comb begin
    state_d     = state_q;
    p_valid_d   = p_valid_q;
    p_idx_d     = p_idx_q;
    cnt_d       = cnt_q;
    vld_d       = vld_q;
    we          = 1'b0;
    waddr       = p_idx_q;
    wdata       = cur - CountOne;
    re          = 1'b0;
    raddr       = cnt_q[IdxW-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.func == sct_pkg::FuncTick) begin
            state_d   = StSweep;
            cnt_d     = '0;
            p_valid_d = 1'b0;
          end else if (set_in_range) begin
            we           = 1'b1;
            waddr        = set_slot6[IdxW-1:0];
            wdata        = set_val;
            vld_d[waddr] = 1'b1;
          end
        end
      end
      StSweep: begin
        if (adv) begin
          if (p_valid_q && (cur != '0)) begin
            we = 1'b1;
          end
          if (p_wake) begin
            out_valid_d       = 1'b1;
            out_d.is_wake     = 1'b1;
            out_d.wake_slot   = p_idx6[4:0];
            out_d.last        = 1'b0;
          end
          if (cnt_q < NumSlotsC) begin
            re        = 1'b1;
            p_valid_d = 1'b1;
            p_idx_d   = cnt_q[IdxW-1:0];
            cnt_d     = cnt_q + CntW'(1);
          end else begin
            p_valid_d = 1'b0;
            state_d   = StMark;
          end
        end
      end
      StMark: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.is_wake   = 1'b0;
          out_d.wake_slot = '0;
          out_d.last      = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vld_q       <= '0;
      p_valid_q   <= 1'b0;
      p_idx_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      p_valid_q   <= p_valid_d;
      p_idx_q     <= p_idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.func == sct_pkg::FuncTick) |=> in_stall_o)
    else $error("tick accepted but block not busy");

  a_wake_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_wake |-> !out_data_o.last)
    else $error("wake beat flagged last");

  a_pipe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (state_q == StSweep))
    else $error("sweep stage valid outside sweep");

  a_mark_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMark) |-> !p_valid_q && (cnt_q == NumSlotsC))
    else $error("marker state before sweep finished");

endmodule

>>> tb/sleep_countdown_table_core_tb.sv
// Testbench for sleep_countdown_table_core: random and directed set/tick traffic.
module sleep_countdown_table_core_tb;

  localparam int unsigned NumSlots  = 32;
  localparam int unsigned CountW    = 16;
  localparam int unsigned SlotW     = sct_pkg::SlotW;
  localparam int unsigned TicksW    = sct_pkg::TicksW;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainWait = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  sct_pkg::in_beat_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sct_pkg::out_beat_t out_data_o;

  logic [CountW-1:0]  countdown [NumSlots];
  sct_pkg::out_beat_t pending_wakes[$];
  int unsigned        mismatches = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        in_idle_pct = 0;
  int unsigned        out_stall_pct = 0;
  int unsigned        stall_left = 0;

  sleep_countdown_table_core #(
    .NUM_SLOTS  (NumSlots),
    .COUNT_WIDTH(CountW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // counters decrement per tick; each one hitting zero wakes, then the marker
  function automatic void predict_item(input sct_pkg::in_beat_t b);
    sct_pkg::out_beat_t w;
    if (b.func == sct_pkg::FuncSet) begin
      if (b.slot < NumSlots) countdown[b.slot] = b.ticks;
    end else begin
      for (int i = 0; i < NumSlots; i++) begin
        if (countdown[i] != '0) begin
          countdown[i] = countdown[i] - 1'b1;
          if (countdown[i] == '0) begin
            w.is_wake   = 1'b1;
            w.wake_slot = i[SlotW-1:0];
            w.last      = 1'b0;
            pending_wakes.push_back(w);
          end
        end
      end
      w.is_wake   = 1'b0;
      w.wake_slot = '0;
      w.last      = 1'b1;
      pending_wakes.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    sct_pkg::out_beat_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pending_wakes.size() == 0) begin
        report_mismatch("unexpected beat, slot", 0, out_data_o.wake_slot);
      end else begin
        e = pending_wakes.pop_front();
        if (out_data_o.is_wake !== e.is_wake)
          report_mismatch("is_wake", e.is_wake, out_data_o.is_wake);
        if (out_data_o.wake_slot !== e.wake_slot)
          report_mismatch("wake_slot", e.wake_slot, out_data_o.wake_slot);
        if (out_data_o.last !== e.last)
          report_mismatch("last", e.last, out_data_o.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < out_stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(9) == 0) ? $urandom_range(40, 8) - 1
                                              : $urandom_range(3, 1) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge the beat is taken
  task automatic send_beat(input sct_pkg::in_beat_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(b);
  endtask

  task automatic put_item(input logic func, input logic [SlotW-1:0] slot,
                          input logic [TicksW-1:0] ticks);
    sct_pkg::in_beat_t b;
    int unsigned       gap;
    b.func  = func;
    b.slot  = slot;
    b.ticks = ticks;
    send_beat(b);
    gap = 0;
    if ($urandom_range(99) < in_idle_pct)
      gap = ($urandom_range(4) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      in_data_i  <= sct_pkg::in_beat_t'(($bits(sct_pkg::in_beat_t))'($urandom));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [TicksW-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 75) return TicksW'($urandom_range(6, 1));
    return TicksW'($urandom_range(16'hFFFF, 0));
  endfunction

  task automatic test_empty_tick();
    put_item(sct_pkg::FuncTick, 5'd31, 16'hFFFF);
  endtask

  task automatic test_set_and_expire();
    put_item(sct_pkg::FuncSet, 5'd0, 16'd1);
    put_item(sct_pkg::FuncSet, 5'd31, 16'd1);
    put_item(sct_pkg::FuncSet, 5'd7, 16'd2);
    put_item(sct_pkg::FuncSet, 5'd5, 16'hFFFF);
    put_item(sct_pkg::FuncSet, 5'd10, 16'hAAAA);
    put_item(sct_pkg::FuncSet, 5'd12, 16'h5555);
    put_item(sct_pkg::FuncTick, 5'd0, 16'h0000);
    put_item(sct_pkg::FuncTick, 5'd21, 16'h1234);
  endtask

  task automatic test_cancel_and_overwrite();
    put_item(sct_pkg::FuncSet, 5'd5, 16'd0);
    put_item(sct_pkg::FuncSet, 5'd3, 16'd3);
    put_item(sct_pkg::FuncSet, 5'd3, 16'd1);
    put_item(sct_pkg::FuncSet, 5'd20, 16'd2);
    put_item(sct_pkg::FuncSet, 5'd20, 16'd0);
    put_item(sct_pkg::FuncSet, 5'd10, 16'd0);
    put_item(sct_pkg::FuncTick, 5'd0, 16'd0);
  endtask

  task automatic test_full_sweep();
    int unsigned order [NumSlots];
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < NumSlots; i++) order[i] = i;
    for (int i = NumSlots - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NumSlots; i++) put_item(sct_pkg::FuncSet, SlotW'(order[i]), 16'd1);
    put_item(sct_pkg::FuncTick, SlotW'($urandom), TicksW'($urandom));
  endtask

  task automatic test_random_traffic(input int unsigned n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 35)
        put_item(sct_pkg::FuncTick, SlotW'($urandom), TicksW'($urandom));
      else
        put_item(sct_pkg::FuncSet, SlotW'($urandom_range(NumSlots - 1)), rand_count());
    end
  endtask

  initial begin
    foreach (countdown[i]) countdown[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tick();
    test_set_and_expire();
    test_cancel_and_overwrite();

    in_idle_pct   = 20;
    out_stall_pct = 20;
    test_full_sweep();

    in_idle_pct   = 0;
    out_stall_pct = 0;
    test_random_traffic(150);
    in_idle_pct   = 30;
    out_stall_pct = 30;
    test_random_traffic(140);
    in_idle_pct   = 60;
    out_stall_pct = 70;
    test_random_traffic(140);

    in_valid_i    <= 1'b0;
    out_stall_pct = 10;
    while (pending_wakes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
